// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; each macro expands to one clocked concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/bsdc_pkg.sv
// constants, month-length tables, lookup functions and shared types
// for the bikram sambat date converter; no dependencies
package bsdc_pkg;

	// field widths
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 6;
	localparam int unsigned WDAY_W  = 3;

	// calendar constants
	localparam int unsigned FIRST_YEAR_C   = 2000;
	localparam int unsigned YEAR_COUNT_DEF = 91;
	localparam int unsigned KNOWN_YEARS    = 91;
	localparam int unsigned MONTHS         = 12;
	localparam int unsigned MAX_BS_DAY     = 32;
	localparam int unsigned EPOCH_YEAR     = 1943;
	localparam int unsigned EPOCH_MONTH    = 4;
	localparam int unsigned EPOCH_DAY      = 13;
	// days from 1 january 1943 to the epoch day
	localparam int unsigned EPOCH_DOY      = 102;
	// any gregorian year above this lies past the end of the table
	localparam int unsigned LAST_GR_YEAR   = 2040;
	localparam int unsigned GR_FEB_IDX     = 1;
	localparam int unsigned WEEK_DAYS      = 7;

	// datapath widths
	localparam int unsigned ACC_W      = 16;
	localparam int unsigned GYEAR_W    = 11;
	localparam int unsigned ROW_W      = 4;
	localparam int unsigned MLEN_W     = 6;
	localparam int unsigned GMLEN_W    = 5;
	localparam int unsigned YLEN_W     = 9;
	localparam int unsigned WSH_W      = 4;
	localparam int unsigned WSHIFT_MAX = 12;

	// table rows: five irregular head rows, then five rows that repeat
	localparam int unsigned HEAD_ROWS = 5;
	localparam int unsigned ROW_COUNT = 10;

	typedef logic [ROW_W-1:0] row_t;

	localparam logic [MLEN_W-1:0] BS_MONTH_DAYS [ROW_COUNT][MONTHS] = '{
		'{6'd30, 6'd29, 6'd30, 6'd29, 6'd30, 6'd29, 6'd30, 6'd29, 6'd30, 6'd29, 6'd30, 6'd30},
		'{6'd31, 6'd31, 6'd31, 6'd32, 6'd31, 6'd30, 6'd30, 6'd29, 6'd30, 6'd29, 6'd30, 6'd30},
		'{6'd31, 6'd31, 6'd32, 6'd31, 6'd31, 6'd29, 6'd30, 6'd30, 6'd29, 6'd30, 6'd29, 6'd31},
		'{6'd30, 6'd31, 6'd32, 6'd32, 6'd31, 6'd30, 6'd29, 6'd30, 6'd29, 6'd30, 6'd29, 6'd30},
		'{6'd30, 6'd30, 6'd32, 6'd32, 6'd31, 6'd30, 6'd29, 6'd30, 6'd29, 6'd30, 6'd29, 6'd30},
		'{6'd31, 6'd31, 6'd32, 6'd31, 6'd31, 6'd31, 6'd30, 6'd29, 6'd30, 6'd29, 6'd30, 6'd30},
		'{6'd30, 6'd31, 6'd32, 6'd32, 6'd31, 6'd30, 6'd30, 6'd29, 6'd30, 6'd29, 6'd30, 6'd30},
		'{6'd30, 6'd31, 6'd32, 6'd32, 6'd31, 6'd30, 6'd30, 6'd29, 6'd30, 6'd29, 6'd30, 6'd30},
		'{6'd31, 6'd32, 6'd31, 6'd32, 6'd31, 6'd30, 6'd30, 6'd30, 6'd29, 6'd30, 6'd29, 6'd31},
		'{6'd31, 6'd31, 6'd31, 6'd32, 6'd31, 6'd31, 6'd29, 6'd30, 6'd30, 6'd29, 6'd30, 6'd30}
	};

	// row sums of the table above
	localparam logic [YLEN_W-1:0] BS_YEAR_DAYS [ROW_COUNT] = '{
		9'd355, 9'd364, 9'd364, 9'd363, 9'd362, 9'd365, 9'd364, 9'd364, 9'd366, 9'd365
	};

	localparam logic [GMLEN_W-1:0] GR_MONTH_DAYS [MONTHS] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// lookup request from the sequencer
	typedef struct packed {
		row_t               row;
		logic               known;
		logic [MONTH_W-1:0] mon;
		logic               leap;
	} len_req_t;

	// lengths handed back to the sequencer
	typedef struct packed {
		logic [MLEN_W-1:0]  bs_mdays;
		logic [YLEN_W-1:0]  bs_ydays;
		logic [GMLEN_W-1:0] gr_mdays;
		logic [YLEN_W-1:0]  gr_ydays;
	} len_rsp_t;

	// bs month length, zero for rows past the known years
	function automatic logic [MLEN_W-1:0] bs_month_days(input row_t row, input logic known,
		input logic [MONTH_W-1:0] mon);
		logic [MLEN_W-1:0] len;
		len = '0;
		if (known && (row < ROW_W'(ROW_COUNT)) && (mon < MONTH_W'(MONTHS))) begin
			len = BS_MONTH_DAYS[row][mon];
		end
		return len;
	endfunction

	// bs year length, zero for rows past the known years
	function automatic logic [YLEN_W-1:0] bs_year_days(input row_t row, input logic known);
		logic [YLEN_W-1:0] len;
		len = '0;
		if (known && (row < ROW_W'(ROW_COUNT))) begin
			len = BS_YEAR_DAYS[row];
		end
		return len;
	endfunction

	// gregorian month length, month counted from zero
	function automatic logic [GMLEN_W-1:0] greg_month_days(input logic leap,
		input logic [MONTH_W-1:0] mon0);
		logic [GMLEN_W-1:0] len;
		len = '0;
		if (mon0 == MONTH_W'(GR_FEB_IDX) && leap) begin
			len = 5'd29;
		end else if (mon0 < MONTH_W'(MONTHS)) begin
			len = GR_MONTH_DAYS[mon0];
		end
		return len;
	endfunction

	function automatic logic [YLEN_W-1:0] greg_year_days(input logic leap);
		return leap ? 9'd366 : 9'd365;
	endfunction

	// next table row: after the last cycle row comes the first cycle row
	function automatic row_t next_row(input row_t row);
		return (row == ROW_W'(ROW_COUNT - 1)) ? ROW_W'(HEAD_ROWS) : row + ROW_W'(1);
	endfunction

endpackage

// File: hw/rtl/bsdc_req_if.sv
// request channel of the date converter: valid/ready and the input date
// depends on bsdc_pkg
interface bsdc_req_if import bsdc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               mode;
	logic [YEAR_W-1:0]  in_year;
	logic [MONTH_W-1:0] in_month;
	logic [DAY_W-1:0]   in_day;

	modport source (output valid, mode, in_year, in_month, in_day, input ready);
	modport sink (input valid, mode, in_year, in_month, in_day, output ready);
endinterface

// File: hw/rtl/bsdc_rsp_if.sv
// response channel of the date converter: valid/ready and the converted date
// depends on bsdc_pkg
interface bsdc_rsp_if import bsdc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               valid_res;
	logic [YEAR_W-1:0]  out_year;
	logic [MONTH_W-1:0] out_month;
	logic [DAY_W-1:0]   out_day;
	logic [WDAY_W-1:0]  weekday;

	modport source (output valid, valid_res, out_year, out_month, out_day, weekday,
		input ready);
	modport sink (input valid, valid_res, out_year, out_month, out_day, weekday,
		output ready);
endinterface

// File: hw/rtl/bikram_sambat_date_converter.sv
// bikram sambat <-> gregorian date converter, one item at a time. bs to ad walks bs years from
// 2000 and months, weekday reduction, then gregorian years from 1943 and months; ad to bs walks
// gregorian years and months, weekday reduction, epoch rebase, then bs years and months. inputs
// refused by the entry checks go straight to done. one add/subtract unit walks one table entry
// per cycle. throughput: next item accepted the cycle after the result moves to the output
// register. reset: arst_n clears the sequencer and the output valid; tables are constants.
module bikram_sambat_date_converter import bsdc_pkg::*; #(
	parameter int unsigned YEAR_COUNT = YEAR_COUNT_DEF
) (
	input logic         clk,
	input logic         arst_n,
	bsdc_req_if.sink    req,
	bsdc_rsp_if.source  rsp
);

	localparam int unsigned IDX_W = $clog2(YEAR_COUNT + 1);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_BS_YEAR  = 8'b0000_0010,
		S_BS_MONTH = 8'b0000_0100,
		S_GR_YEAR  = 8'b0000_1000,
		S_GR_MONTH = 8'b0001_0000,
		S_WDAY     = 8'b0010_0000,
		S_EPOCH    = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic                mode_q;
	logic                ok_q;
	logic [MONTH_W-1:0]  mon_q;
	logic [DAY_W-1:0]    day_q;
	logic [IDX_W-1:0]    tidx_q;
	logic [GYEAR_W-1:0]  gtgt_q;
	logic [ACC_W-1:0]    acc_q;
	logic [ACC_W-1:0]    aux_q;
	logic [IDX_W-1:0]    bidx_q;
	row_t                row_q;
	logic [MONTH_W-1:0]  mcnt_q;
	logic [GYEAR_W-1:0]  gyear_q;
	logic [WSH_W-1:0]    wsh_q;

	logic                rsp_valid_q;
	logic                valid_res_q;
	logic [YEAR_W-1:0]   out_year_q;
	logic [MONTH_W-1:0]  out_month_q;
	logic [DAY_W-1:0]    out_day_q;
	logic [WDAY_W-1:0]   weekday_q;

	len_req_t            lookup;
	len_rsp_t            lengths;

	logic [ACC_W-1:0]    alu_a;
	logic [ACC_W-1:0]    alu_b;
	logic                alu_sub;
	logic [ACC_W:0]      alu_sum;
	logic [ACC_W-1:0]    alu_res;
	logic                alu_neg;

	logic                mon_last;
	logic                load;

	logic [YEAR_W-1:0]   year_off;
	logic                in_m_ok;
	logic                bs_ok;
	logic                gr_leap_in;
	logic                gr_d_ok;
	logic                gr_early;
	logic                ad_ok;
	logic                start_ok;

	logic [WDAY_W-1:0]   wd_rem;
	logic [WDAY_W-1:0]   wd_res;

	// length lookup for the current walk position
	assign lookup.row   = row_q;
	assign lookup.known = (32'(bidx_q) < 32'(KNOWN_YEARS));
	assign lookup.mon   = mcnt_q;
	assign lookup.leap  = (gyear_q[1:0] == 2'b00);

	bsdc_len_lut u_len_lut (
		.lookup  (lookup),
		.lengths (lengths)
	);

	// input checks for the incoming item
	always_comb begin
		year_off   = req.in_year - YEAR_W'(FIRST_YEAR_C);
		in_m_ok    = (req.in_month != '0) && (req.in_month <= MONTH_W'(MONTHS));
		bs_ok      = (req.in_year >= YEAR_W'(FIRST_YEAR_C)) && (year_off < YEAR_W'(YEAR_COUNT))
			&& in_m_ok && (req.in_day != '0) && (req.in_day <= DAY_W'(MAX_BS_DAY));
		gr_leap_in = (req.in_year[1:0] == 2'b00);
		gr_d_ok    = (req.in_day != '0) && (req.in_day <= DAY_W'(greg_month_days(gr_leap_in,
			req.in_month - MONTH_W'(1))));
		gr_early   = (req.in_year == YEAR_W'(EPOCH_YEAR))
			&& ((req.in_month < MONTH_W'(EPOCH_MONTH))
			|| ((req.in_month == MONTH_W'(EPOCH_MONTH)) && (req.in_day < DAY_W'(EPOCH_DAY))));
		ad_ok      = (req.in_year >= YEAR_W'(EPOCH_YEAR)) && (req.in_year <= YEAR_W'(LAST_GR_YEAR))
			&& in_m_ok && gr_d_ok && !gr_early;
		start_ok   = req.mode ? ad_ok : bs_ok;
	end

	assign mon_last = (mcnt_q == (mon_q - MONTH_W'(1)));

	// operand selection for the shared add/subtract unit
	always_comb begin
		alu_a   = acc_q;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			S_BS_YEAR: begin
				alu_b   = ACC_W'(lengths.bs_ydays);
				alu_sub = mode_q;
			end
			S_BS_MONTH: begin
				alu_b   = (!mode_q && mon_last) ? ACC_W'(day_q - DAY_W'(1))
					: ACC_W'(lengths.bs_mdays);
				alu_sub = mode_q;
			end
			S_GR_YEAR: begin
				alu_b   = ACC_W'(lengths.gr_ydays);
				alu_sub = !mode_q;
			end
			S_GR_MONTH: begin
				alu_b   = (mode_q && mon_last) ? ACC_W'(day_q - DAY_W'(1))
					: ACC_W'(lengths.gr_mdays);
				alu_sub = !mode_q;
			end
			S_WDAY: begin
				alu_a   = aux_q;
				alu_b   = ACC_W'(WEEK_DAYS) << wsh_q;
				alu_sub = 1'b1;
			end
			S_EPOCH: begin
				alu_b   = ACC_W'(EPOCH_DOY);
				alu_sub = 1'b1;
			end
			default: begin
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	// shared adder; top bit flags a negative difference
	assign alu_sum = {1'b0, alu_a} + ({1'b0, alu_b} ^ {(ACC_W + 1){alu_sub}})
		+ (ACC_W + 1)'(alu_sub);
	assign alu_res = alu_sum[ACC_W-1:0];
	assign alu_neg = alu_sum[ACC_W];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= !start_ok ? S_DONE : (req.mode ? S_GR_YEAR : S_BS_YEAR);
					end
				end
				S_BS_YEAR: begin
					if (!mode_q) begin
						if (bidx_q == tidx_q) begin
							state_q <= S_BS_MONTH;
						end
					end else if (bidx_q == IDX_W'(YEAR_COUNT)) begin
						state_q <= S_DONE;
					end else if (alu_neg) begin
						state_q <= S_BS_MONTH;
					end
				end
				S_BS_MONTH: begin
					if (!mode_q) begin
						if (mon_last) begin
							state_q <= (day_q > lengths.bs_mdays) ? S_DONE : S_WDAY;
						end
					end else if (mcnt_q == MONTH_W'(MONTHS) || alu_neg) begin
						state_q <= S_DONE;
					end
				end
				S_GR_YEAR: begin
					if (mode_q ? (gyear_q == gtgt_q) : alu_neg) begin
						state_q <= S_GR_MONTH;
					end
				end
				S_GR_MONTH: begin
					if (!mode_q && alu_neg) begin
						state_q <= S_DONE;
					end else if (mode_q && mon_last) begin
						state_q <= S_WDAY;
					end
				end
				S_WDAY: begin
					if (wsh_q == '0) begin
						state_q <= mode_q ? S_EPOCH : S_GR_YEAR;
					end
				end
				S_EPOCH: begin
					state_q <= S_BS_YEAR;
				end
				S_DONE: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers of the walk
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				mode_q  <= req.mode;
				mon_q   <= req.in_month;
				day_q   <= req.in_day;
				tidx_q  <= year_off[IDX_W-1:0];
				gtgt_q  <= req.in_year[GYEAR_W-1:0];
				acc_q   <= req.mode ? '0 : ACC_W'(EPOCH_DOY);
				bidx_q  <= '0;
				row_q   <= '0;
				mcnt_q  <= '0;
				gyear_q <= GYEAR_W'(EPOCH_YEAR);
				ok_q    <= 1'b0;
			end
			S_BS_YEAR: begin
				if (!(mode_q ? (bidx_q == IDX_W'(YEAR_COUNT) || alu_neg) : (bidx_q == tidx_q)))
				begin
					acc_q  <= alu_res;
					bidx_q <= bidx_q + IDX_W'(1);
					row_q  <= next_row(row_q);
				end
			end
			S_BS_MONTH: begin
				if (!mode_q) begin
					acc_q <= alu_res;
					if (mon_last) begin
						aux_q <= alu_res;
						wsh_q <= WSH_W'(WSHIFT_MAX);
					end else begin
						mcnt_q <= mcnt_q + MONTH_W'(1);
					end
				end else if (mcnt_q != MONTH_W'(MONTHS)) begin
					if (alu_neg) begin
						ok_q <= 1'b1;
					end else begin
						acc_q  <= alu_res;
						mcnt_q <= mcnt_q + MONTH_W'(1);
					end
				end
			end
			S_GR_YEAR: begin
				if (mode_q ? (gyear_q == gtgt_q) : alu_neg) begin
					mcnt_q <= '0;
				end else begin
					acc_q   <= alu_res;
					gyear_q <= gyear_q + GYEAR_W'(1);
				end
			end
			S_GR_MONTH: begin
				if (!mode_q && alu_neg) begin
					ok_q <= 1'b1;
				end else begin
					acc_q <= alu_res;
					if (mode_q && mon_last) begin
						aux_q <= alu_res;
						wsh_q <= WSH_W'(WSHIFT_MAX);
					end else begin
						mcnt_q <= mcnt_q + MONTH_W'(1);
					end
				end
			end
			S_WDAY: begin
				// restoring reduction of the day count modulo seven
				if (!alu_neg) begin
					aux_q <= alu_res;
				end
				wsh_q <= wsh_q - WSH_W'(1);
			end
			S_EPOCH: begin
				// rebase on the bs epoch and restart the table walk
				acc_q  <= alu_res;
				bidx_q <= '0;
				row_q  <= '0;
				mcnt_q <= '0;
			end
			default: begin
			end
		endcase
	end

	// weekday from days since 1 january 1943, a friday
	assign wd_rem = aux_q[WDAY_W-1:0];
	assign wd_res = (wd_rem < 3'd3) ? wd_rem + 3'd5 : wd_rem - 3'd2;

	assign load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			valid_res_q <= ok_q;
			if (ok_q) begin
				out_year_q  <= mode_q ? YEAR_W'(FIRST_YEAR_C) + YEAR_W'(bidx_q)
					: YEAR_W'(gyear_q);
				out_month_q <= mcnt_q + MONTH_W'(1);
				out_day_q   <= acc_q[DAY_W-1:0] + DAY_W'(1);
				weekday_q   <= wd_res;
			end else begin
				out_year_q  <= '0;
				out_month_q <= '0;
				out_day_q   <= '0;
				weekday_q   <= '0;
			end
		end
	end

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.valid_res = valid_res_q;
	assign rsp.out_year  = out_year_q;
	assign rsp.out_month = out_month_q;
	assign rsp.out_day   = out_day_q;
	assign rsp.weekday   = weekday_q;

endmodule

// File: hw/rtl/bsdc_len_lut.sv
// month and year length lookup for both calendars
// depends on bsdc_pkg (tables and lookup functions)
module bsdc_len_lut import bsdc_pkg::*; (
	input  len_req_t lookup,
	output len_rsp_t lengths
);

	// constant table reads, one per length
	always_comb begin
		lengths.bs_mdays = bs_month_days(lookup.row, lookup.known, lookup.mon);
		lengths.bs_ydays = bs_year_days(lookup.row, lookup.known);
		lengths.gr_mdays = greg_month_days(lookup.leap, lookup.mon);
		lengths.gr_ydays = greg_year_days(lookup.leap);
	end

endmodule

// File: hw/rtl/bsdc_checker.sv
// port-level checks for the date converter, bound to the top level
// depends on assert_macros.svh and bikram_sambat_date_converter
`include "assert_macros.svh"

module bsdc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_valid_res,
	input logic [13:0] rsp_out_year,
	input logic [3:0] rsp_out_month,
	input logic [5:0] rsp_out_day,
	input logic [2:0] rsp_weekday
);

	// a stalled item stays offered
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "rsp item dropped")

	// a stalled item keeps its fields
	`ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp_valid_res) && $stable(rsp_out_year) && $stable(rsp_out_month) && $stable(rsp_out_day) && $stable(rsp_weekday), "rsp item changed while stalled")

	// rejected dates come back with all fields cleared
	`ASSERT_IMPL(a_invalid_zero, clk, arst_n, rsp_valid && !rsp_valid_res, rsp_out_year == 14'd0 && rsp_out_month == 4'd0 && rsp_out_day == 6'd0 && rsp_weekday == 3'd0, "rejected item with nonzero fields")

	// converted dates are well formed
	`ASSERT_IMPL(a_valid_range, clk, arst_n, rsp_valid && rsp_valid_res, rsp_out_month != 4'd0 && rsp_out_month <= 4'd12 && rsp_out_day != 6'd0 && rsp_out_day <= 6'd32 && rsp_weekday != 3'd0, "converted date out of range")

	// one conversion at a time
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready, "item accepted while busy")

endmodule

bind bikram_sambat_date_converter bsdc_checker u_bsdc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_valid_res (rsp.valid_res),
	.rsp_out_year  (rsp.out_year),
	.rsp_out_month (rsp.out_month),
	.rsp_out_day   (rsp.out_day),
	.rsp_weekday   (rsp.weekday)
);
